@@ sv/rmq_pkg.sv @@
// shared constants for the rotation matrix to quaternion block
// no dependencies
`default_nettype none
package rmq_pkg;
   localparam int FRAC_BITS_DEF = 14;
   localparam int IO_W          = 16;
endpackage
`default_nettype wire

@@ sv/rmq_isqrt.sv @@
// pipelined integer square root, two radicand bits per stage
// no package dependencies; sideband payload rides along with each item
`default_nettype none
module rmq_isqrt #(
   parameter int DW = 19,
   parameter int SW = 1
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire logic [2*DW-1:0]   in_n,
   input  wire logic [SW-1:0]     in_side,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output logic [DW-1:0]          out_root,
   output logic [SW-1:0]          out_side
);
   localparam int NW = 2 * DW;
   localparam int RW = DW + 3;

   logic            v_ff    [DW];
   logic [RW-1:0]   rem_ff  [DW];
   logic [DW-1:0]   root_ff [DW];
   logic [NW-1:0]   n_ff    [DW];
   logic [SW-1:0]   side_ff [DW];
   logic            rdy     [DW+1];

   assign rdy[DW] = out_ready;

   for (genvar k = 0; k < DW; k++) begin : g_stage
      logic            p_v;
      logic [RW-1:0]   p_rem;
      logic [DW-1:0]   p_root;
      logic [NW-1:0]   p_n;
      logic [SW-1:0]   p_side;
      logic [RW-1:0]   cur;
      logic [RW-1:0]   trial;
      logic [RW-1:0]   rem_in;
      logic [DW-1:0]   root_in;

      if (k == 0) begin : g_first
         assign p_v    = in_valid;
         assign p_rem  = '0;
         assign p_root = '0;
         assign p_n    = in_n;
         assign p_side = in_side;
      end else begin : g_next
         assign p_v    = v_ff[k-1];
         assign p_rem  = rem_ff[k-1];
         assign p_root = root_ff[k-1];
         assign p_n    = n_ff[k-1];
         assign p_side = side_ff[k-1];
      end

      assign rdy[k] = !v_ff[k] || rdy[k+1];

      always_comb begin
         cur   = {p_rem[DW:0], p_n[NW-1-2*k -: 2]};
         trial = {1'b0, p_root, 2'b01};
         if (cur >= trial) begin
            rem_in  = cur - trial;
            root_in = {p_root[DW-2:0], 1'b1};
         end else begin
            rem_in  = cur;
            root_in = {p_root[DW-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (rdy[k]) begin
            v_ff[k] <= p_v;
         end
         if (rdy[k]) begin
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
            n_ff[k]    <= p_n;
            side_ff[k] <= p_side;
         end
      end
   end

   assign in_ready  = rdy[0];
   assign out_valid = v_ff[DW-1];
   assign out_root  = root_ff[DW-1];
   assign out_side  = side_ff[DW-1];
endmodule
`default_nettype wire

@@ sv/rmq_div.sv @@
// pipelined four-lane restoring divider, one quotient bit per stage
// no package dependencies; all lanes share one divisor
`default_nettype none
module rmq_div #(
   parameter int NMW = 34,
   parameter int DENW = 20,
   parameter int QW = 15,
   parameter int SW = 5
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_valid,
   output logic                       in_ready,
   input  wire logic [DENW-1:0]       in_den,
   input  wire logic [3:0][NMW-1:0]   in_num,
   input  wire logic [SW-1:0]         in_side,
   output logic                       out_valid,
   input  wire logic                  out_ready,
   output logic [3:0][QW-1:0]         out_q,
   output logic [SW-1:0]              out_side
);
   logic                  v_ff    [QW];
   logic [3:0][NMW-1:0]   rem_ff  [QW];
   logic [3:0][QW-1:0]    q_ff    [QW];
   logic [DENW-1:0]       den_ff  [QW];
   logic [SW-1:0]         side_ff [QW];
   logic                  rdy     [QW+1];

   assign rdy[QW] = out_ready;

   for (genvar j = 0; j < QW; j++) begin : g_stage
      logic                  p_v;
      logic [3:0][NMW-1:0]   p_rem;
      logic [3:0][QW-1:0]    p_q;
      logic [DENW-1:0]       p_den;
      logic [SW-1:0]         p_side;
      logic [NMW-1:0]        sh;
      logic [3:0][NMW-1:0]   rem_in;
      logic [3:0][QW-1:0]    q_in;

      if (j == 0) begin : g_first
         assign p_v    = in_valid;
         assign p_rem  = in_num;
         assign p_q    = '0;
         assign p_den  = in_den;
         assign p_side = in_side;
      end else begin : g_next
         assign p_v    = v_ff[j-1];
         assign p_rem  = rem_ff[j-1];
         assign p_q    = q_ff[j-1];
         assign p_den  = den_ff[j-1];
         assign p_side = side_ff[j-1];
      end

      assign rdy[j] = !v_ff[j] || rdy[j+1];

      always_comb begin
         sh = NMW'(p_den) << (QW - 1 - j);
         for (int i = 0; i < 4; i++) begin
            if (p_rem[i] >= sh) begin
               rem_in[i] = p_rem[i] - sh;
               q_in[i]   = {p_q[i][QW-2:0], 1'b1};
            end else begin
               rem_in[i] = p_rem[i];
               q_in[i]   = {p_q[i][QW-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[j] <= 1'b0;
         end else if (rdy[j]) begin
            v_ff[j] <= p_v;
         end
         if (rdy[j]) begin
            rem_ff[j]  <= rem_in;
            q_ff[j]    <= q_in;
            den_ff[j]  <= p_den;
            side_ff[j] <= p_side;
         end
      end
   end

   assign in_ready  = rdy[0];
   assign out_valid = v_ff[QW-1];
   assign out_q     = q_ff[QW-1];
   assign out_side  = side_ff[QW-1];
endmodule
`default_nettype wire

@@ sv/rotation_matrix_to_quaternion_top.sv @@
// top level: rotation matrix to normalized quaternion, fully pipelined
// depends on rmq_pkg, rmq_isqrt and rmq_div
`default_nettype none
// A matrix transfer can be taken every cycle while no stall holds the pipeline; each result
// passes through single register stages, the square root pipeline (one root bit per
// stage) and the divider (one quotient bit per stage). Stalls on the result side fill
// bubbles first and only then hold the request side. A non-positive radicand yields the
// identity quaternion.
module rotation_matrix_to_quaternion_top #(
   parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic signed [rmq_pkg::IO_W-1:0]  req_x_axis_x,
   input  wire logic signed [rmq_pkg::IO_W-1:0]  req_x_axis_y,
   input  wire logic signed [rmq_pkg::IO_W-1:0]  req_x_axis_z,
   input  wire logic signed [rmq_pkg::IO_W-1:0]  req_y_axis_x,
   input  wire logic signed [rmq_pkg::IO_W-1:0]  req_y_axis_y,
   input  wire logic signed [rmq_pkg::IO_W-1:0]  req_y_axis_z,
   input  wire logic signed [rmq_pkg::IO_W-1:0]  req_z_axis_x,
   input  wire logic signed [rmq_pkg::IO_W-1:0]  req_z_axis_y,
   input  wire logic signed [rmq_pkg::IO_W-1:0]  req_z_axis_z,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic signed [rmq_pkg::IO_W-1:0]       rsp_quat_w,
   output logic signed [rmq_pkg::IO_W-1:0]       rsp_quat_x,
   output logic signed [rmq_pkg::IO_W-1:0]       rsp_quat_y,
   output logic signed [rmq_pkg::IO_W-1:0]       rsp_quat_z
);
   import rmq_pkg::*;

   localparam int F    = FRAC_BITS;
   localparam int MW   = (F > 16) ? F + 1 : 18;
   localparam int CW   = MW + 1;
   localparam int NW   = 2 * MW + 2;
   localparam int DW   = MW + 1;
   localparam int DENW = DW + 1;
   localparam int QW   = F + 1;
   localparam int NMW  = MW + F + 2;
   localparam int S1W  = 4 * MW + 5;
   localparam int S2W  = 5;
   localparam logic signed [CW-1:0] ONE_S = {{(CW-F-1){1'b0}}, 1'b1, {F{1'b0}}};
   localparam logic [31:0] ONE_32 = 32'd1 << F;

   // stage 1: branch select and raw components
   logic signed [CW-1:0] e00, e10, e20, e01, e11, e21, e02, e12, e22;
   logic signed [CW-1:0] trace, r;
   logic signed [CW-1:0] c_in [4];
   logic signed [CW-1:0] c_ff [4];
   logic                 ident1_ff;
   logic                 v1_ff, rdy1;

   assign e00 = CW'(req_x_axis_x);
   assign e10 = CW'(req_x_axis_y);
   assign e20 = CW'(req_x_axis_z);
   assign e01 = CW'(req_y_axis_x);
   assign e11 = CW'(req_y_axis_y);
   assign e21 = CW'(req_y_axis_z);
   assign e02 = CW'(req_z_axis_x);
   assign e12 = CW'(req_z_axis_y);
   assign e22 = CW'(req_z_axis_z);

   always_comb begin
      trace = e00 + e11 + e22;
      if (!trace[CW-1] && trace != '0) begin
         r = ONE_S + trace;
         c_in[0] = r;         c_in[1] = e21 - e12;
         c_in[2] = e02 - e20; c_in[3] = e10 - e01;
      end else if (e00 > e11 && e00 > e22) begin
         r = ONE_S + e00 - e11 - e22;
         c_in[0] = e21 - e12; c_in[1] = r;
         c_in[2] = e01 + e10; c_in[3] = e02 + e20;
      end else if (e11 > e22) begin
         r = ONE_S + e11 - e00 - e22;
         c_in[0] = e02 - e20; c_in[1] = e01 + e10;
         c_in[2] = r;         c_in[3] = e12 + e21;
      end else begin
         r = ONE_S + e22 - e00 - e11;
         c_in[0] = e10 - e01; c_in[1] = e02 + e20;
         c_in[2] = e12 + e21; c_in[3] = r;
      end
   end

   // stage 2: magnitudes and squares
   logic [MW-1:0]   mag_in  [4];
   logic [MW-1:0]   mag2_ff [4];
   logic [2*MW-1:0] sq_ff   [4];
   logic [3:0]      sgn2_ff;
   logic            ident2_ff;
   logic            v2_ff, rdy2;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         mag_in[i] = c_ff[i][CW-1] ? MW'(-c_ff[i]) : MW'(c_ff[i]);
      end
   end

   // stage 3: sum of squares
   logic [NW-1:0]   n_in, n_ff;
   logic [MW-1:0]   mag3_ff [4];
   logic [3:0]      sgn3_ff;
   logic            ident3_ff;
   logic            v3_ff, rdy3;

   assign n_in = NW'(sq_ff[0]) + NW'(sq_ff[1]) + NW'(sq_ff[2]) + NW'(sq_ff[3]);

   // square root
   logic            sq_in_ready, sq_out_valid;
   logic [DW-1:0]   root;
   logic [S1W-1:0]  s1_side_in, s1_side_out;

   assign s1_side_in = {ident3_ff, sgn3_ff, mag3_ff[3], mag3_ff[2], mag3_ff[1], mag3_ff[0]};

   // stage 4: divider operands
   logic [DW-1:0]           dd;
   logic [DENW-1:0]         den_ff;
   logic [3:0][NMW-1:0]     num_in, num_ff;
   logic [S2W-1:0]          s2_side_ff;
   logic                    v4_ff, rdy4;

   always_comb begin
      dd = (root == '0) ? DW'(1) : root;
      for (int i = 0; i < 4; i++) begin
         num_in[i] = (NMW'(s1_side_out[i*MW +: MW]) << (F + 1)) + NMW'(dd);
      end
   end

   // divider
   logic                 div_in_ready, div_out_valid;
   logic [3:0][QW-1:0]   quo;
   logic [S2W-1:0]       s2_side_out;

   // stage 5: clamp and output register
   logic                 v5_ff, rdy5;
   logic [IO_W-1:0]      res_in [4];
   logic [IO_W-1:0]      res_ff [4];
   logic [31:0]          lim, mg;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         lim = 32'(quo[i]);
         if (lim > ONE_32) begin
            lim = ONE_32;
         end
         if (s2_side_out[i]) begin
            mg = (lim > 32'd32768) ? 32'd32768 : lim;
            res_in[i] = IO_W'(32'd0 - mg);
         end else begin
            mg = (lim > 32'd32767) ? 32'd32767 : lim;
            res_in[i] = IO_W'(mg);
         end
      end
      if (s2_side_out[4]) begin
         mg = (ONE_32 > 32'd32767) ? 32'd32767 : ONE_32;
         res_in[0] = IO_W'(mg);
         res_in[1] = '0;
         res_in[2] = '0;
         res_in[3] = '0;
      end
   end

   assign rdy5 = !v5_ff || !rsp_stall;
   assign rdy4 = !v4_ff || div_in_ready;
   assign rdy3 = !v3_ff || sq_in_ready;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;
   assign req_stall = !rdy1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= req_valid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= sq_out_valid;
         if (rdy5) v5_ff <= div_out_valid;
      end
      if (rdy1) begin
         for (int i = 0; i < 4; i++) c_ff[i] <= c_in[i];
         ident1_ff <= r[CW-1] || r == '0;
      end
      if (rdy2) begin
         for (int i = 0; i < 4; i++) begin
            mag2_ff[i] <= mag_in[i];
            sq_ff[i]   <= mag_in[i] * mag_in[i];
            sgn2_ff[i] <= c_ff[i][CW-1];
         end
         ident2_ff <= ident1_ff;
      end
      if (rdy3) begin
         n_ff      <= n_in;
         for (int i = 0; i < 4; i++) mag3_ff[i] <= mag2_ff[i];
         sgn3_ff   <= sgn2_ff;
         ident3_ff <= ident2_ff;
      end
      if (rdy4) begin
         den_ff     <= {dd, 1'b0};
         num_ff     <= num_in;
         s2_side_ff <= s1_side_out[S1W-1 -: S2W];
      end
      if (rdy5) begin
         for (int i = 0; i < 4; i++) res_ff[i] <= res_in[i];
      end
   end

   rmq_isqrt #(
      .DW (DW),
      .SW (S1W)
   ) u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v3_ff),
      .in_ready  (sq_in_ready),
      .in_n      (n_ff),
      .in_side   (s1_side_in),
      .out_valid (sq_out_valid),
      .out_ready (rdy4),
      .out_root  (root),
      .out_side  (s1_side_out)
   );

   rmq_div #(
      .NMW  (NMW),
      .DENW (DENW),
      .QW   (QW),
      .SW   (S2W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v4_ff),
      .in_ready  (div_in_ready),
      .in_den    (den_ff),
      .in_num    (num_ff),
      .in_side   (s2_side_ff),
      .out_valid (div_out_valid),
      .out_ready (rdy5),
      .out_q     (quo),
      .out_side  (s2_side_out)
   );

   assign rsp_valid  = v5_ff;
   assign rsp_quat_w = res_ff[0];
   assign rsp_quat_x = res_ff[1];
   assign rsp_quat_y = res_ff[2];
   assign rsp_quat_z = res_ff[3];

   a_reset_empty : assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");
   a_accept_lands : assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> v1_ff)
      else $error("accepted transfer not captured in first stage");
   a_result_held : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("stalled result dropped");
endmodule
`default_nettype wire

@@ bench/tb.sv @@
// testbench for rotation_matrix_to_quaternion_top: directed and random matrices
// with random idling on both channels, checked against an in-bench quaternion predictor
// depends on rmq_pkg and the rotation_matrix_to_quaternion_top rtl
`timescale 1ns / 100ps
module tb;
   localparam int W = rmq_pkg::IO_W;
   localparam int FB = rmq_pkg::FRAC_BITS_DEF;
   localparam int LATENCY = FB + 24;

   typedef logic signed [W-1:0] word_type;
   typedef struct packed {
      word_type m00, m10, m20, m01, m11, m21, m02, m12, m22;
   } matrix_type;
   typedef struct packed {
      word_type w, x, y, z;
   } quat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   matrix_type req_m = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   word_type rsp_w, rsp_x, rsp_y, rsp_z;
   logic req_taken = 1'b0;

   matrix_type pending_matrices[$];
   quat_type expected_quats[$];
   int errors = 0;
   int driver_gap = 0;
   int monitor_gap = 0;
   bit stimulus_done = 1'b0;

   rotation_matrix_to_quaternion_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_x_axis_x(req_m.m00), .req_x_axis_y(req_m.m10), .req_x_axis_z(req_m.m20),
      .req_y_axis_x(req_m.m01), .req_y_axis_y(req_m.m11), .req_y_axis_z(req_m.m21),
      .req_z_axis_x(req_m.m02), .req_z_axis_y(req_m.m12), .req_z_axis_z(req_m.m22),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_quat_w(rsp_w), .rsp_quat_x(rsp_x), .rsp_quat_y(rsp_y), .rsp_quat_z(rsp_z)
   );

   always #5 clock = ~clock;

   function automatic longint unsigned int_sqrt(longint unsigned n);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic word_type clamp_unit(longint v);
      longint one;
      one = longint'(1) << FB;
      if (v > one) v = one;
      if (v < -one) v = -one;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return word_type'(v);
   endfunction

   function automatic quat_type matrix_to_quat(matrix_type m);
      longint one, a00, a10, a20, a01, a11, a21, a02, a12, a22, r;
      longint c[4];
      longint unsigned n2, d, mg, q;
      quat_type res;
      one = longint'(1) << FB;
      a00 = m.m00; a10 = m.m10; a20 = m.m20;
      a01 = m.m01; a11 = m.m11; a21 = m.m21;
      a02 = m.m02; a12 = m.m12; a22 = m.m22;
      if (a00 + a11 + a22 > 0) begin
         r = one + a00 + a11 + a22;
         c[0] = r; c[1] = a21 - a12; c[2] = a02 - a20; c[3] = a10 - a01;
      end else if (a00 > a11 && a00 > a22) begin
         r = one + a00 - a11 - a22;
         c[0] = a21 - a12; c[1] = r; c[2] = a01 + a10; c[3] = a02 + a20;
      end else if (a11 > a22) begin
         r = one + a11 - a00 - a22;
         c[0] = a02 - a20; c[1] = a01 + a10; c[2] = r; c[3] = a12 + a21;
      end else begin
         r = one + a22 - a00 - a11;
         c[0] = a10 - a01; c[1] = a02 + a20; c[2] = a12 + a21; c[3] = r;
      end
      if (r <= 0) begin
         res.w = clamp_unit(one);
         res.x = '0; res.y = '0; res.z = '0;
         return res;
      end
      n2 = 0;
      for (int i = 0; i < 4; i++) begin
         mg = (c[i] < 0) ? longint'(-c[i]) : longint'(c[i]);
         n2 += mg * mg;
      end
      d = int_sqrt(n2);
      if (d == 0) d = 1;
      for (int i = 0; i < 4; i++) begin
         mg = (c[i] < 0) ? longint'(-c[i]) : longint'(c[i]);
         q = (mg * longint'(one) * 2 + d) / (2 * d);
         c[i] = (c[i] < 0) ? -longint'(q) : longint'(q);
      end
      res.w = clamp_unit(c[0]); res.x = clamp_unit(c[1]);
      res.y = clamp_unit(c[2]); res.z = clamp_unit(c[3]);
      return res;
   endfunction

   function automatic word_type rand_elem();
      int k;
      k = $urandom_range(0, 9);
      if (k == 0) return word_type'($urandom);
      if (k == 1) return word_type'(16384);
      if (k == 2) return word_type'(-16384);
      return word_type'($urandom_range(0, 32768) - 16384);
   endfunction

   // random orthonormal-ish matrix: signed permutation with small noise
   function automatic matrix_type rand_rotation();
      int p, s0, s1, s2, rot;
      word_type e[9];
      matrix_type m;
      for (int i = 0; i < 9; i++) e[i] = word_type'($urandom_range(0, 400) - 200);
      p = $urandom_range(0, 2);
      rot = $urandom_range(0, 1);
      s0 = $urandom_range(0, 1) ? 16384 : -16384;
      s1 = $urandom_range(0, 1) ? 16384 : -16384;
      s2 = $urandom_range(0, 1) ? 16384 : -16384;
      e[(0 + p) % 3] = word_type'(s0 - e[(0 + p) % 3] / 4);
      e[3 + (1 + p + rot) % 3] = word_type'(s1);
      e[6 + (2 + p + 2 * rot) % 3] = word_type'(s2);
      m.m00 = e[0]; m.m10 = e[1]; m.m20 = e[2];
      m.m01 = e[3]; m.m11 = e[4]; m.m21 = e[5];
      m.m02 = e[6]; m.m12 = e[7]; m.m22 = e[8];
      return m;
   endfunction

   task automatic monitor_gap_step();
      if (monitor_gap > 0) begin
         rsp_stall <= 1'b1;
         monitor_gap <= monitor_gap - 1;
      end else begin
         rsp_stall <= 1'b0;
      end
   endtask

   initial begin
      matrix_type m;
      m = '0; m.m00 = 16384; m.m11 = 16384; m.m22 = 16384;
      pending_matrices.push_back(m);
      m = '0; m.m00 = 16384; m.m11 = -16384; m.m22 = -16384;
      pending_matrices.push_back(m);
      m = '0; m.m00 = -16384; m.m11 = 16384; m.m22 = -16384;
      pending_matrices.push_back(m);
      m = '0; m.m00 = -16384; m.m11 = -16384; m.m22 = 16384;
      pending_matrices.push_back(m);
      m = '0; m.m01 = -16384; m.m10 = 16384; m.m22 = 16384;
      pending_matrices.push_back(m);
      m = '0;
      pending_matrices.push_back(m);
      m = '0; m.m00 = -16384; m.m11 = -16384; m.m22 = -16384;
      pending_matrices.push_back(m);
      m = {9{word_type'(16'sh7fff)}};
      pending_matrices.push_back(m);
      m = {9{word_type'(16'sh8000)}};
      pending_matrices.push_back(m);
      m = {9{word_type'(16'shffff)}};
      pending_matrices.push_back(m);
      m = {9{word_type'(16'sh5555)}};
      pending_matrices.push_back(m);
      m = {9{word_type'(16'shaaaa)}};
      pending_matrices.push_back(m);
      m = '0; m.m00 = 16384; m.m11 = 16383; m.m22 = -16384; m.m12 = 16384; m.m21 = -16384;
      pending_matrices.push_back(m);
      m = '0; m.m00 = 11585; m.m01 = -11585; m.m10 = 11585; m.m11 = 11585; m.m22 = 16384;
      pending_matrices.push_back(m);
      m = '0; m.m00 = 16384; m.m11 = 16384; m.m22 = -16384;
      pending_matrices.push_back(m);
      for (int i = 0; i < 535; i++) begin
         if ($urandom_range(0, 3) != 0) begin
            m = rand_rotation();
         end else begin
            m.m00 = rand_elem(); m.m10 = rand_elem(); m.m20 = rand_elem();
            m.m01 = rand_elem(); m.m11 = rand_elem(); m.m21 = rand_elem();
            m.m02 = rand_elem(); m.m12 = rand_elem(); m.m22 = rand_elem();
         end
         pending_matrices.push_back(m);
      end
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
   end

   // driver
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_valid || req_taken) begin
            if (driver_gap > 0 || pending_matrices.size() == 0) begin
               req_valid <= 1'b0;
               if (driver_gap > 0) driver_gap <= driver_gap - 1;
               if (pending_matrices.size() == 0) stimulus_done <= 1'b1;
            end else begin
               req_m <= pending_matrices.pop_front();
               req_valid <= 1'b1;
               driver_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
            end
         end
         monitor_gap_step();
      end
   end

   // monitor and prediction at the rising edge
   always @(posedge clock) begin
      quat_type exp_q;
      req_taken <= !reset && req_valid && !req_stall;
      if (!reset && req_valid && !req_stall)
         expected_quats.push_back(matrix_to_quat(req_m));
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_quats.size() == 0) begin
            $display("%0t: unexpected transfer w=%0d x=%0d y=%0d z=%0d",
                     $time, rsp_w, rsp_x, rsp_y, rsp_z);
            errors++;
         end else begin
            exp_q = expected_quats.pop_front();
            if (rsp_w !== exp_q.w) begin
               $display("%0t: quat_w expected %0d actual %0d", $time, exp_q.w, rsp_w);
               errors++;
            end
            if (rsp_x !== exp_q.x) begin
               $display("%0t: quat_x expected %0d actual %0d", $time, exp_q.x, rsp_x);
               errors++;
            end
            if (rsp_y !== exp_q.y) begin
               $display("%0t: quat_y expected %0d actual %0d", $time, exp_q.y, rsp_y);
               errors++;
            end
            if (rsp_z !== exp_q.z) begin
               $display("%0t: quat_z expected %0d actual %0d", $time, exp_q.z, rsp_z);
               errors++;
            end
         end
         if ($urandom_range(0, 3) != 0) monitor_gap <= $urandom_range(0, 9);
      end
   end

   initial begin
      wait (stimulus_done && expected_quats.size() == 0);
      repeat (LATENCY + 10) @(posedge clock);
      if (errors == 0 && expected_quats.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("tb: failure");
      $finish;
   end
endmodule
